// ===== hdl/bav_pkg.sv =====
// Shared types, constants and the interval step function of the button auto-repeat adjuster.
package bav_pkg;

  // Number of buttons served and the width of a button address.
  localparam int NUM_BUTTONS = 2;
  localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Width of the interval, the hold counter and the registers.
  localparam int VAL_W = 16;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_STEP_SIZE     = 3'd0;
  localparam cfg_idx_t CFG_LOWER_LIMIT   = 3'd1;
  localparam cfg_idx_t CFG_UPPER_LIMIT   = 3'd2;
  localparam cfg_idx_t CFG_REPEAT_DELAY  = 3'd3;
  localparam cfg_idx_t CFG_REPEAT_PERIOD = 3'd4;
  localparam cfg_idx_t CFG_START_VALUE   = 3'd5;

  // Register values after reset.
  localparam logic [VAL_W-1:0] RST_STEP_SIZE     = 16'd100;
  localparam logic [VAL_W-1:0] RST_LOWER_LIMIT   = 16'd100;
  localparam logic [VAL_W-1:0] RST_UPPER_LIMIT   = 16'd60000;
  localparam logic [VAL_W-1:0] RST_REPEAT_DELAY  = 16'd500;
  localparam logic [VAL_W-1:0] RST_REPEAT_PERIOD = 16'd100;
  localparam logic [VAL_W-1:0] RST_START_VALUE   = 16'd1000;

  // Cycle count of the remainder unit, one dividend bit per cycle.
  localparam int DIV_CW = $clog2(VAL_W);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(VAL_W - 1);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  // Per-button entry of the state memory.
  typedef struct packed {
    logic             prev_level;
    logic             pres_level;
    logic [VAL_W-1:0] hold;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // A released button with a cleared hold counter.
  localparam entry_t ENTRY_RESET = '{prev_level: 1'b1, pres_level: 1'b1, hold: '0};

  // Outcome of one interval step.
  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] value;
  } step_t;

  // One step of the interval, blocked by the limits and saturating at both ends.
  function automatic step_t apply_step(input logic [VAL_W-1:0] cur,
                                       input logic [VAL_W-1:0] step,
                                       input logic [VAL_W-1:0] lower,
                                       input logic [VAL_W-1:0] upper,
                                       input logic             faster);
    step_t          r;
    logic [VAL_W:0] sum;
    r.ok    = 1'b0;
    r.value = cur;
    sum     = {1'b0, cur} + {1'b0, step};
    if (faster) begin
      if (cur > lower) begin
        r.ok    = 1'b1;
        r.value = (cur > step) ? (cur - step) : '0;
      end
    end else begin
      if (cur < upper) begin
        r.ok    = 1'b1;
        r.value = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/button_autorepeat_value_adjuster_core.sv =====
// Top level of the button auto-repeat adjuster: sequencer, state memory and remainder unit.
//
// Each request on the slave side is one sampling tick of one button; it yields exactly one
// result on the master side carrying the shared interval after the tick, whether a step was
// applied and whether a new press was seen. The per-button level history and hold counters
// live in a small synchronous RAM that is read, updated and written back once per tick, while
// the shared interval and the registers sit in flip-flops. A tick passes from the lookup state
// straight to the result state when no repeat check is due, and through the divide state when
// the hold count has passed the repeat delay and its remainder by the repeat period must be found:
// the remainder unit resolves one bit of the 16-bit hold count per cycle. s_axis_tready is high only
// while the sequencer is idle. A finished result waits in an output register, so the next tick
// is taken while it is still pending. After reset every button reads as released with a
// cleared hold counter, by means of one valid bit per memory entry; there is no clearing pass.
// Register writes are always ready and are to be made while no tick is in flight; writing the
// start value also reloads the interval.
module button_autorepeat_value_adjuster_core (
  input  logic                          clk,
  input  logic                          rst,
  // Tick requests.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // level, increase, zero fill
  input  logic                          s_axis_tuser,  // button_id
  // Results.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // interval_value, changed, press_edge, zero fill
  // Register writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bav_pkg::VAL_W-1:0]     cfg_data
);

  localparam int AW = bav_pkg::BTN_AW;
  localparam int VW = bav_pkg::VAL_W;

  bav_pkg::state_t state, state_next;

  // Registers; the start value only reloads the interval and is not kept.
  logic [VW-1:0] step_size, lower_limit, upper_limit;
  logic [VW-1:0] repeat_delay, repeat_period;

  // Shared interval.
  logic [VW-1:0] interval;

  // Captured tick.
  logic [AW-1:0] btn;
  logic          in_range;
  logic          level;
  logic          increase;
  logic          changed;
  logic          press_edge;

  // Entry valid bits and state memory ports.
  logic [bav_pkg::NUM_BUTTONS-1:0] ent_valid;
  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  logic [bav_pkg::ENT_W-1:0]       ram_rdata;
  bav_pkg::entry_t                 ram_wentry;

  // Remainder unit.
  logic [VW-1:0]             div_rem;
  logic [VW-1:0]             div_num;
  logic [bav_pkg::DIV_CW-1:0] div_cnt;
  logic [VW:0]               div_shift;
  logic [VW:0]               div_diff;
  logic [VW-1:0]             div_rem_next;

  // Lookup stage values.
  bav_pkg::entry_t cur_entry;
  logic            edge_det;
  logic [VW-1:0]   hold_base;
  logic [VW-1:0]   hold_inc;
  logic            need_div;
  bav_pkg::step_t  step_res;

  // Output register.
  logic          out_valid;
  logic [VW-1:0] out_value;
  logic          out_changed;
  logic          out_edge;
  logic          out_free;
  logic          in_accept;

  assign s_axis_tready = (state == bav_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_edge, out_changed, out_value};

  // Memory read address comes straight from the request.
  assign ram_raddr = AW'(s_axis_tuser);

  bav_ram #(
    .WIDTH (bav_pkg::ENT_W),
    .DEPTH (bav_pkg::NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (btn),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read-modify-write of the button entry; a never written entry reads as released.
  always_comb begin
    cur_entry = ent_valid[btn] ? bav_pkg::entry_t'(ram_rdata) : bav_pkg::ENTRY_RESET;
    edge_det  = in_range && !level && cur_entry.pres_level;
    hold_base = edge_det ? '0 : cur_entry.hold;
    hold_inc  = hold_base + VW'(1);
    need_div  = in_range && !level && (hold_inc > repeat_delay) && (repeat_period != '0);
    ram_we    = (state == bav_pkg::ST_LOOKUP) && in_range;
    ram_wentry.prev_level = cur_entry.pres_level;
    ram_wentry.pres_level = level;
    ram_wentry.hold       = level ? '0 : hold_inc;
  end

  // Step on the current interval, used for the press and for the repeat.
  assign step_res = bav_pkg::apply_step(interval, step_size, lower_limit, upper_limit, increase);

  // One restoring remainder step per cycle.
  always_comb begin
    div_shift    = {div_rem, div_num[VW-1]};
    div_diff     = div_shift - {1'b0, repeat_period};
    div_rem_next = div_diff[VW] ? div_shift[VW-1:0] : div_diff[VW-1:0];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bav_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bav_pkg::ST_IDLE: begin
        if (in_accept) state_next = bav_pkg::ST_LOOKUP;
      end
      bav_pkg::ST_LOOKUP: begin
        state_next = need_div ? bav_pkg::ST_DIVIDE : bav_pkg::ST_RESULT;
      end
      bav_pkg::ST_DIVIDE: begin
        if (div_cnt == bav_pkg::DIV_LAST) state_next = bav_pkg::ST_RESULT;
      end
      bav_pkg::ST_RESULT: begin
        if (out_free) state_next = bav_pkg::ST_IDLE;
      end
      default: state_next = bav_pkg::ST_IDLE;
    endcase
  end

  // Tick capture, entry valid bits, interval updates and the remainder unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      interval  <= bav_pkg::RST_START_VALUE;
    end else begin
      if (state == bav_pkg::ST_LOOKUP && in_range) begin
        ent_valid[btn] <= 1'b1;
      end
      if (state == bav_pkg::ST_LOOKUP && edge_det && step_res.ok) begin
        interval <= step_res.value;
      end
      if (state == bav_pkg::ST_DIVIDE && div_cnt == bav_pkg::DIV_LAST &&
          div_rem_next == '0 && step_res.ok) begin
        interval <= step_res.value;
      end
      if (cfg_valid && cfg_index == bav_pkg::CFG_START_VALUE) begin
        interval <= cfg_data;
      end
    end

    if (in_accept) begin
      btn      <= AW'(s_axis_tuser);
      in_range <= ({{(32 - 1){1'b0}}, s_axis_tuser} < 32'(bav_pkg::NUM_BUTTONS));
      level    <= s_axis_tdata[0];
      increase <= s_axis_tdata[1];
      changed  <= 1'b0;
    end

    if (state == bav_pkg::ST_LOOKUP) begin
      press_edge <= edge_det;
      if (edge_det && step_res.ok) changed <= 1'b1;
      div_rem <= '0;
      div_num <= hold_inc;
      div_cnt <= '0;
    end

    if (state == bav_pkg::ST_DIVIDE) begin
      div_rem <= div_rem_next;
      div_num <= {div_num[VW-2:0], 1'b0};
      div_cnt <= div_cnt + bav_pkg::DIV_CW'(1);
      if (div_cnt == bav_pkg::DIV_LAST && div_rem_next == '0 && step_res.ok) begin
        changed <= 1'b1;
      end
    end
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size     <= bav_pkg::RST_STEP_SIZE;
      lower_limit   <= bav_pkg::RST_LOWER_LIMIT;
      upper_limit   <= bav_pkg::RST_UPPER_LIMIT;
      repeat_delay  <= bav_pkg::RST_REPEAT_DELAY;
      repeat_period <= bav_pkg::RST_REPEAT_PERIOD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bav_pkg::CFG_STEP_SIZE:     step_size     <= cfg_data;
        bav_pkg::CFG_LOWER_LIMIT:   lower_limit   <= cfg_data;
        bav_pkg::CFG_UPPER_LIMIT:   upper_limit   <= cfg_data;
        bav_pkg::CFG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
        bav_pkg::CFG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: loaded when the tick is finished and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bav_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end

    if (state == bav_pkg::ST_RESULT && out_free) begin
      out_value   <= interval;
      out_changed <= changed;
      out_edge    <= press_edge;
    end
  end

endmodule

// ===== hdl/bav_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/button_autorepeat_value_adjuster_core_tb.sv =====
// Self-checking testbench for the button auto-repeat interval adjuster core.
`timescale 1ns / 100ps

module button_autorepeat_value_adjuster_core_tb;
  import bav_pkg::*;

  // Indexes past the end of the register map; writes to them must be ignored.
  localparam cfg_idx_t CFG_UNMAPPED_LO = 3'd6;
  localparam cfg_idx_t CFG_UNMAPPED_HI = 3'd7;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_TICKS  = 165;
  localparam int unsigned SETTLE_WAIT  = 25;
  localparam int unsigned LONG_HOLDOFF = 400;

  // One expected result of a tick.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             changed;
    logic             press;
  } outcome_t;

  // Tracks the adjuster state, predicts each result and checks what comes out.
  class adjust_scoreboard;
    logic [VAL_W-1:0] step_size;
    logic [VAL_W-1:0] lower_limit;
    logic [VAL_W-1:0] upper_limit;
    logic [VAL_W-1:0] repeat_delay;
    logic [VAL_W-1:0] repeat_period;
    logic [VAL_W-1:0] interval;
    logic             prev_lvl [NUM_BUTTONS];
    logic             pres_lvl [NUM_BUTTONS];
    logic [VAL_W-1:0] hold_cnt [NUM_BUTTONS];
    outcome_t         expected_q [$];
    int unsigned      mismatches;
    int unsigned      ticks;
    int unsigned      presses;
    int unsigned      repeats;
    int unsigned      adjusted;

    function new();
      step_size     = 16'd100;
      lower_limit   = 16'd100;
      upper_limit   = 16'd60000;
      repeat_delay  = 16'd500;
      repeat_period = 16'd100;
      interval      = 16'd1000;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        prev_lvl[i] = 1'b1;
        pres_lvl[i] = 1'b1;
        hold_cnt[i] = '0;
      end
    endfunction

    // One step of the shared interval; returns 1 if the limits let it through.
    function bit take_step(logic faster);
      logic [VAL_W:0] sum;
      sum = {1'b0, interval} + {1'b0, step_size};
      if (faster) begin
        if (interval <= lower_limit) return 1'b0;
        interval = (interval > step_size) ? interval - step_size : '0;
      end else begin
        if (interval >= upper_limit) return 1'b0;
        interval = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
      end
      return 1'b1;
    endfunction

    // A register write; the start value also reloads the interval.
    function void note_write(cfg_idx_t idx, logic [VAL_W-1:0] val);
      case (idx)
        CFG_STEP_SIZE:     step_size = val;
        CFG_LOWER_LIMIT:   lower_limit = val;
        CFG_UPPER_LIMIT:   upper_limit = val;
        CFG_REPEAT_DELAY:  repeat_delay = val;
        CFG_REPEAT_PERIOD: repeat_period = val;
        CFG_START_VALUE:   interval = val;
        default: ;
      endcase
    endfunction

    // An accepted tick request: shift the level history, handle press and repeat.
    function void note_tick(logic btn, logic lvl, logic faster);
      outcome_t o;
      int       b;
      b         = int'(btn);
      o.changed = 1'b0;
      o.press   = 1'b0;
      prev_lvl[b] = pres_lvl[b];
      pres_lvl[b] = lvl;
      if (!pres_lvl[b] && prev_lvl[b]) begin
        o.press = 1'b1;
        presses++;
        if (take_step(faster)) o.changed = 1'b1;
        hold_cnt[b] = '0;
      end
      if (!pres_lvl[b]) begin
        hold_cnt[b] = hold_cnt[b] + 16'd1;
        if (hold_cnt[b] > repeat_delay && repeat_period != 0 &&
            (hold_cnt[b] % repeat_period) == 0) begin
          repeats++;
          if (take_step(faster)) o.changed = 1'b1;
        end
      end else begin
        hold_cnt[b] = '0;
      end
      o.value = interval;
      if (o.changed) adjusted++;
      ticks++;
      expected_q.push_back(o);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // An accepted result, compared with the oldest expectation.
    task check_result(logic [23:0] data);
      outcome_t o;
      if (expected_q.size() == 0) begin
        report($sformatf("result 0x%06h with nothing expected", data));
        return;
      end
      o = expected_q.pop_front();
      if (data[15:0] !== o.value)
        report($sformatf("interval %0d, expected %0d", data[15:0], o.value));
      if (data[16] !== o.changed)
        report($sformatf("changed %b, expected %b", data[16], o.changed));
      if (data[17] !== o.press)
        report($sformatf("press_edge %b, expected %b", data[17], o.press));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // level, increase, zero fill
  logic             s_axis_tuser = 1'b0; // button_id
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;        // interval_value, changed, press_edge, zero fill
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  adjust_scoreboard sb = new();

  int unsigned burst_left   = 0;
  bit          sender_calm  = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          rx_long_hold = 1'b0;
  int unsigned settings     = 1;

  button_autorepeat_value_adjuster_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Result receiver: random ready runs and stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned run_left;
    int unsigned stall_left;
    run_left   = 0;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLDOFF) @(posedge clk);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 20);
          stall_left = (rx_calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Offers one tick request and waits for it to be taken; gaps fall between bursts.
  task automatic offer_tick(logic btn, logic lvl, logic inc);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= btn;
    s_axis_tdata  <= {6'b0, inc, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_tick(btn, lvl, inc);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register setting of one random phase, with the extremes spread over the phases.
  task automatic program_phase(int unsigned p);
    logic [VAL_W-1:0] step_v, low_v, up_v, dly_v, per_v, start_v;
    step_v  = 16'($urandom_range(1, 3000));
    low_v   = 16'($urandom_range(0, 20000));
    up_v    = 16'($urandom_range(30000, 65535));
    dly_v   = 16'($urandom_range(0, 12));
    per_v   = 16'($urandom_range(1, 6));
    start_v = 16'($urandom);
    case (p)
      0: start_v = 16'd0;
      1: begin
        dly_v = 16'd0;
        per_v = 16'd1;
      end
      2: begin
        low_v = 16'd0;
        up_v  = 16'hFFFF;
      end
      3: step_v = 16'd0;
      4: begin
        up_v  = 16'd0;
        per_v = 16'd0;
      end
      5: begin
        step_v  = 16'hFFFF;
        start_v = 16'hFFFF;
      end
      6: begin
        low_v = 16'hFFFF;
        per_v = 16'hFFFF;
      end
      default: begin
        dly_v = 16'hFFFF;
        low_v = 16'($urandom);
        up_v  = 16'($urandom);
      end
    endcase
    write_reg(CFG_STEP_SIZE, step_v);
    write_reg(CFG_LOWER_LIMIT, low_v);
    write_reg(CFG_UPPER_LIMIT, up_v);
    write_reg(CFG_REPEAT_DELAY, dly_v);
    write_reg(CFG_REPEAT_PERIOD, per_v);
    if ($urandom_range(0, 1) != 0) write_reg(CFG_UNMAPPED_HI, 16'($urandom));
    write_reg(CFG_START_VALUE, start_v);
    settings++;
  endtask

  // Mostly press, hold and release gestures with stray ticks from the other button mixed in.
  task automatic run_phase(int unsigned n_ticks, bit pause_midway);
    int unsigned sent;
    int unsigned len;
    logic        btn;
    logic        inc;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_ticks) begin
      if (pause_midway && !paused && sent >= n_ticks / 2) begin
        settle();
        paused = 1'b1;
      end
      btn = 1'($urandom_range(0, 1));
      inc = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            offer_tick(~btn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
          end
          if ($urandom_range(0, 11) == 0) inc = ~inc;
          offer_tick(btn, 1'b0, inc);
          sent++;
        end
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          offer_tick(btn, 1'b1, inc);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          offer_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: plain presses on both buttons, one in each direction.
    offer_tick(1'b0, 1'b1, 1'b0);
    offer_tick(1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b0);
    offer_tick(1'b1, 1'b0, 1'b0);
    offer_tick(1'b1, 1'b1, 1'b0);

    // Decrease past zero saturates, then the lower limit blocks a press.
    settle();
    write_reg(CFG_LOWER_LIMIT, 16'd0);
    write_reg(CFG_STEP_SIZE, 16'hFFFF);
    write_reg(CFG_UNMAPPED_LO, 16'h5A5A);
    write_reg(CFG_UNMAPPED_HI, 16'hA5A5);
    offer_tick(1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b1, 1'b1);
    offer_tick(1'b0, 1'b0, 1'b1);

    // Increase up to the top value, then the upper limit blocks a press.
    settle();
    write_reg(CFG_UPPER_LIMIT, 16'hFFFF);
    offer_tick(1'b1, 1'b0, 1'b0);
    offer_tick(1'b1, 1'b1, 1'b0);
    offer_tick(1'b1, 1'b0, 1'b0);

    // Zero repeat period never repeats; a zero step still counts as a change.
    settle();
    write_reg(CFG_STEP_SIZE, 16'd0);
    write_reg(CFG_REPEAT_PERIOD, 16'd0);
    write_reg(CFG_REPEAT_DELAY, 16'd0);
    offer_tick(1'b1, 1'b0, 1'b1);
    offer_tick(1'b1, 1'b0, 1'b1);
    offer_tick(1'b1, 1'b1, 1'b1);
    offer_tick(1'b1, 1'b0, 1'b1);

    // Press and repeat on the same tick apply two steps.
    settle();
    write_reg(CFG_REPEAT_PERIOD, 16'd1);
    write_reg(CFG_STEP_SIZE, 16'd1);
    offer_tick(1'b0, 1'b1, 1'b1);
    offer_tick(1'b0, 1'b0, 1'b1);
    offer_tick(1'b0, 1'b0, 1'b1);

    // Random phases, each under its own register setting.
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      program_phase(p);
      sender_calm = (p == 3);
      rx_calm     = (p == 3);
      if (p == 2) rx_long_hold = 1'b1;
      run_phase(PHASE_TICKS, p == 4);
    end

    settle();
    $display("Covered %0d ticks under %0d register settings: %0d presses, %0d repeat checks due,",
             sb.ticks, settings, sb.presses, sb.repeats);
    $display("%0d ticks adjusted the interval, including saturation, limits and zero steps.",
             sb.adjusted);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("button_autorepeat_value_adjuster_core_tb OK");
    end else begin
      $display("button_autorepeat_value_adjuster_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("button_autorepeat_value_adjuster_core_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bav_pkg.sv
hdl/bav_ram.sv
hdl/button_autorepeat_value_adjuster_core.sv
verif/button_autorepeat_value_adjuster_core_tb.sv
